// File: src/bnsi_pkg.sv
// ----------------------------------------------------------------------------
// bnsi_pkg
// Shared types, constants and helpers for the bounded top-N sorted table.
// ----------------------------------------------------------------------------
package bnsi_pkg;

   localparam int TableSizeDefault = 16;
   localparam int TagChars         = 3;
   localparam int TagW             = 8 * TagChars;
   localparam int ScoreW           = 32;
   localparam int RoundW           = 16;
   localparam int TimeW            = 32;
   localparam int ReqDataW         = 104;
   localparam int RankW            = 5;
   localparam int RspDataW         = 16;

   typedef struct packed {
      logic [TimeW-1:0]         time_stamp;
      logic [RoundW-1:0]        round_number;
      logic signed [ScoreW-1:0] score_value;
      logic [TagW-1:0]          tag_chars;
   } rec_type;

   typedef struct packed {
      logic insert;
      logic valid;
   } cell_ctl_type;

   // Zero every character after the first zero character
   function automatic logic [TagW-1:0] tag_canon(input logic [TagW-1:0] t);
      logic [TagW-1:0] o;
      logic            stop;
      o    = '0;
      stop = 1'b0;
      for (int k = 0; k < TagChars; k++) begin
         if (t[8*(TagChars-1-k) +: 8] == 8'd0) begin
            stop = 1'b1;
         end
         if (!stop) begin
            o[8*(TagChars-1-k) +: 8] = t[8*(TagChars-1-k) +: 8];
         end
      end
      return o;
   endfunction

endpackage

// File: src/bnsi_cell.sv
// ----------------------------------------------------------------------------
// bnsi_cell
// One table slot: compares against the incoming record, loads it or takes
// the entry of the slot above, and flags a match against the search key.
// ----------------------------------------------------------------------------
module bnsi_cell (
   input  logic                  clock,
   input  bnsi_pkg::cell_ctl_type ctl,
   input  bnsi_pkg::rec_type     new_rec,
   input  bnsi_pkg::rec_type     key_rec,
   input  logic                  prev_at,
   input  bnsi_pkg::rec_type     prev_rec,
   output logic                  at,
   output bnsi_pkg::rec_type     rec,
   output logic                  match
);

   bnsi_pkg::rec_type rec_ff;
   bnsi_pkg::rec_type rec_in;

   // at: this slot lies at or after the insertion point
   assign at    = !ctl.valid || (new_rec.score_value > rec_ff.score_value);
   assign match = ctl.valid && (rec_ff.score_value == key_rec.score_value)
                  && (rec_ff.tag_chars == key_rec.tag_chars);
   assign rec   = rec_ff;

   always_comb begin
      rec_in = rec_ff;
      if (ctl.insert) begin
         if (prev_at) begin
            rec_in = prev_rec;
         end else if (at) begin
            rec_in = new_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

// File: src/bnsi_rank.sv
// ----------------------------------------------------------------------------
// bnsi_rank
// Priority encoder: 1-based position of the first matching slot, 0 if none.
// ----------------------------------------------------------------------------
module bnsi_rank #(
   parameter int TABLE_SIZE = bnsi_pkg::TableSizeDefault
) (
   input  logic [TABLE_SIZE-1:0]             match,
   output logic [$clog2(TABLE_SIZE+1)-1:0]   rank
);

   localparam int CntW = $clog2(TABLE_SIZE + 1);

   always_comb begin
      rank = '0;
      for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
         if (match[i]) begin
            rank = CntW'(i + 1);
         end
      end
   end

endmodule

// File: src/bounded_top_n_sorted_insert_core.sv
// ----------------------------------------------------------------------------
// bounded_top_n_sorted_insert_core
// Top-N table sorted by descending signed score, built as a row of slot cells.
// ----------------------------------------------------------------------------
// channel | dir | handshake           | payload
// req     | in  | req_tvalid/tready   | tag, score, round, timestamp
// rsp     | out | rsp_tvalid/tready   | match rank, inserted flag, count
// csr     | in  | csr_wr_en           | reject_nonpositive
//
// Per transaction: the row updates on the accept edge, then the
// match priority encode runs over the registered slots into the output reg.
// A new request is taken while a response waits; the encode step holds if
// the output register is still full. Synchronous reset empties the table.
// ----------------------------------------------------------------------------
module bounded_top_n_sorted_insert_core #(
   parameter int TABLE_SIZE = bnsi_pkg::TableSizeDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tag_chars[23:0], score_value[55:24], round_number[71:56], time_stamp[103:72]
   input  logic [bnsi_pkg::ReqDataW-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // match_rank[4:0], was_inserted[5], entry_count[10:6], zero[15:11]
   output logic [bnsi_pkg::RspDataW-1:0]  rsp_tdata,
   input  logic                           csr_wr_en,
   input  logic                           csr_wr_data
);

   localparam int CntW = $clog2(TABLE_SIZE + 1);
   localparam int OutW = bnsi_pkg::RankW;

   bnsi_pkg::rec_type new_rec;
   bnsi_pkg::rec_type key_ff, key_in;
   bnsi_pkg::rec_type cell_rec [TABLE_SIZE];
   bnsi_pkg::rec_type prev_rec [TABLE_SIZE];
   bnsi_pkg::cell_ctl_type ctl [TABLE_SIZE];

   logic [TABLE_SIZE-1:0] at;
   logic [TABLE_SIZE-1:0] prev_at;
   logic [TABLE_SIZE-1:0] match;

   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] rank;
   logic            busy_ff, busy_in;
   logic            reject_ff, reject_in;
   logic            ins_ff, ins_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [bnsi_pkg::RspDataW-1:0] rsp_data_ff, rsp_data_in;
   logic [OutW-1:0] rank_out, count_out;
   logic            accept, finish, pass, insert;

   assign new_rec.tag_chars    = bnsi_pkg::tag_canon(req_tdata[23:0]);
   assign new_rec.score_value  = req_tdata[55:24];
   assign new_rec.round_number = req_tdata[71:56];
   assign new_rec.time_stamp   = req_tdata[103:72];

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign finish     = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign pass       = !(reject_ff && (new_rec.score_value <= 0));
   assign insert     = accept && pass && at[TABLE_SIZE-1];

   genvar g;
   generate
      for (g = 0; g < TABLE_SIZE; g++) begin : g_cell
         if (g == 0) begin : g_first
            assign prev_at[g]  = 1'b0;
            assign prev_rec[g] = new_rec;
         end else begin : g_rest
            assign prev_at[g]  = at[g-1];
            assign prev_rec[g] = cell_rec[g-1];
         end
         assign ctl[g].insert = insert;
         assign ctl[g].valid  = (CntW'(g) < count_ff);

         bnsi_cell u_cell (
            .clock    (clock),
            .ctl      (ctl[g]),
            .new_rec  (new_rec),
            .key_rec  (key_ff),
            .prev_at  (prev_at[g]),
            .prev_rec (prev_rec[g]),
            .at       (at[g]),
            .rec      (cell_rec[g]),
            .match    (match[g])
         );
      end

      if (CntW >= OutW) begin : g_wide
         assign rank_out  = rank[OutW-1:0];
         assign count_out = count_ff[OutW-1:0];
      end else begin : g_narrow
         assign rank_out  = {{(OutW-CntW){1'b0}}, rank};
         assign count_out = {{(OutW-CntW){1'b0}}, count_ff};
      end
   endgenerate

   bnsi_rank #(.TABLE_SIZE(TABLE_SIZE)) u_rank (
      .match (match),
      .rank  (rank)
   );

   always_comb begin
      reject_in    = csr_wr_en ? csr_wr_data : reject_ff;
      key_in       = accept ? new_rec : key_ff;
      ins_in       = accept ? insert : ins_ff;
      count_in     = count_ff;
      if (insert && (count_ff < CntW'(TABLE_SIZE))) begin
         count_in = count_ff + CntW'(1);
      end
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (finish) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(bnsi_pkg::RspDataW-2*OutW-1){1'b0}}, count_out, ins_ff, rank_out};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         reject_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         reject_ff    <= reject_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      ins_ff      <= ins_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(TABLE_SIZE))
      else $error("entry count beyond table size");

   a_inserted_found: assert property (@(posedge clock) disable iff (reset)
      (finish && ins_ff) |=> (rsp_tdata[OutW-1:0] != '0 || CntW > OutW))
      else $error("inserted record not found in table");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff >= $past(count_ff)))
      else $error("entry count went down");

   a_idle_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy_ff && !req_tready))
      else $error("request taken while busy");

endmodule
